@@ rtl/pmee_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pmee_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // field widths
  localparam int CHAR_W  = 8;
  localparam int VAL_W   = 31;
  localparam int STAT_W  = 2;
  localparam int PLACE_W = 34;
  localparam int DIGIT_W = 4;
  localparam int PROD_W  = PLACE_W + DIGIT_W;

  localparam logic [CNT_W-1:0]   CNT_FULL    = CNT_W'(STACK_DEPTH);
  localparam logic [VAL_W-1:0]   VALUE_MAX   = {VAL_W{1'b1}};
  localparam logic [PLACE_W-1:0] PLACE_LIMIT = PLACE_W'(VALUE_MAX);

  // character codes
  localparam logic [CHAR_W-1:0] CHR_MIN   = 8'h6D;  // 'm'
  localparam logic [CHAR_W-1:0] CHR_MAX   = 8'h4D;  // 'M'
  localparam logic [CHAR_W-1:0] CHR_COMMA = 8'h2C;  // ','
  localparam logic [CHAR_W-1:0] CHR_LPAR  = 8'h28;  // '('
  localparam logic [CHAR_W-1:0] CHR_RPAR  = 8'h29;  // ')'
  localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHR_NINE  = 8'h39;  // '9'

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

endpackage

`default_nettype wire

@@ rtl/prefix_minmax_expression_evaluator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | valid      | stall       | payload
// --------+------------+-------------+------------------------------
// in      | in_valid_i | in_stall_o  | char_code_i[7:0], last_char_i
// out     | out_valid_o| out_stall_i | value_o[30:0], status_o[1:0]
//
// one character per cycle while in_stall_o is low; a result appears in the
// cycle after the beat that carries the last character.
// the top of stack lives in a register, the rest in a one-read one-write
// ram; the entry under the top is prefetched every cycle and a write to
// the prefetched address is forwarded, so operators never wait.
// reset is asynchronous; the stack ram needs no clearing pass.
// input stalls only while a finished result sits stalled at the output.

module prefix_minmax_expression_evaluator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pmee_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic                           last_char_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [pmee_pkg::VAL_W-1:0]     value_o,
  output logic      [pmee_pkg::STAT_W-1:0]    status_o
);

  import pmee_pkg::*;

  // pending number and stack control
  logic [VAL_W-1:0]   pend_q, pend_d;
  logic [PLACE_W-1:0] place_q, place_d;
  logic               hd_q, hd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VAL_W-1:0]   top_q, top_d;
  logic [STAT_W-1:0]  err_q, err_d;

  // output register
  logic               out_valid_q;
  logic [VAL_W-1:0]   value_q, value_d;
  logic [STAT_W-1:0]  status_q, status_d;

  // ram ports and forwarding
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [VAL_W-1:0]   wr_data, rd_data;
  logic               fwd_q;
  logic [VAL_W-1:0]   fwd_data_q;
  logic [VAL_W-1:0]   second;

  logic               accept;
  logic               is_op;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  sum;
  logic [CNT_W-1:0]   cnt_m1, cnt_m2;

  function automatic logic [VAL_W-1:0] pick(input logic take_min,
                                            input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    logic a_lt;
    a_lt = (a < b);
    return (take_min == a_lt) ? a : b;
  endfunction

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign second     = fwd_q ? fwd_data_q : rd_data;
  assign is_op      = (char_code_i == CHR_MIN) || (char_code_i == CHR_MAX);

  // digit weight times digit value
  assign prod = place_q * PROD_W'(char_code_i[DIGIT_W-1:0]);
  assign sum  = PROD_W'(pend_q) + prod;

  // one character: char effect, then flush, then end of expression
  always_comb begin
    pend_d   = pend_q;
    place_d  = place_q;
    hd_d     = hd_q;
    cnt_d    = cnt_q;
    top_d    = top_q;
    err_d    = err_q;
    wr_en    = 1'b0;
    wr_data  = top_q;
    cnt_m1   = cnt_q - CNT_W'(1);
    wr_addr  = cnt_m1[ADDR_W-1:0];
    value_d  = value_q;
    status_d = status_q;

    if (accept) begin
      // character effect
      case (char_code_i) inside
        [CHR_ZERO:CHR_NINE]: begin
          if ((char_code_i[DIGIT_W-1:0] != '0 && place_q > PLACE_LIMIT) ||
              sum > PROD_W'(VALUE_MAX)) begin
            pend_d = VALUE_MAX;
            if (err_d == ST_OK) err_d = ST_BAD;
          end else begin
            pend_d = sum[VAL_W-1:0];
          end
          if (place_q <= PLACE_LIMIT) begin
            place_d = (place_q << 3) + (place_q << 1);
          end
          hd_d = 1'b1;
        end
        CHR_MIN, CHR_MAX: begin
          if (hd_q) begin
            if (cnt_q == '0) begin
              top_d = pend_q;
              cnt_d = CNT_W'(1);
              if (err_d == ST_OK) err_d = ST_UNDER;
            end else if (cnt_q < CNT_FULL) begin
              top_d = pick(char_code_i == CHR_MIN, pend_q, top_q);
            end else begin
              if (err_d == ST_OK) err_d = ST_OVER;
              top_d = pick(char_code_i == CHR_MIN, top_q, second);
              cnt_d = cnt_m1;
            end
          end else if (cnt_q < CNT_W'(2)) begin
            if (err_d == ST_OK) err_d = ST_UNDER;
          end else begin
            top_d = pick(char_code_i == CHR_MIN, top_q, second);
            cnt_d = cnt_m1;
          end
          pend_d  = '0;
          place_d = PLACE_W'(1);
          hd_d    = 1'b0;
        end
        CHR_COMMA, CHR_LPAR, CHR_RPAR: begin
        end
        default: begin
          if (err_d == ST_OK) err_d = ST_BAD;
        end
      endcase

      // push the pending number on a comma or at the end
      if ((char_code_i == CHR_COMMA || last_char_i) && !is_op && hd_d) begin
        if (cnt_d < CNT_FULL) begin
          wr_en   = (cnt_d != '0);
          wr_data = top_d;
          top_d   = pend_d;
          cnt_d   = cnt_d + CNT_W'(1);
        end else if (err_d == ST_OK) begin
          err_d = ST_OVER;
        end
        pend_d  = '0;
        place_d = PLACE_W'(1);
        hd_d    = 1'b0;
      end

      // end of expression: report and start over
      if (last_char_i) begin
        if (cnt_d == '0) begin
          value_d = '0;
          if (err_d == ST_OK) err_d = ST_UNDER;
        end else begin
          value_d = top_d;
        end
        status_d = err_d;
        pend_d   = '0;
        place_d  = PLACE_W'(1);
        hd_d     = 1'b0;
        cnt_d    = '0;
        err_d    = ST_OK;
      end
    end

    // prefetch the entry under the new top
    cnt_m2  = cnt_d - CNT_W'(2);
    rd_addr = cnt_m2[ADDR_W-1:0];
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      place_q     <= PLACE_W'(1);
      hd_q        <= 1'b0;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      place_q <= place_d;
      hd_q    <= hd_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      fwd_q   <= wr_en && (wr_addr == rd_addr);
      if (accept && last_char_i) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    fwd_data_q <= wr_data;
    value_q    <= value_d;
    status_q   <= status_d;
  end

  pmee_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // stack count stays within the ram
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("stack count beyond depth");

  // an accepted last beat always produces a result beat
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_char_i) |=> out_valid_o)
    else $error("missing result after last beat");

  // expression state is fresh after a result
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_char_i) |=> (cnt_q == '0 && !hd_q && err_q == ST_OK))
    else $error("state not cleared after expression end");

  // digit weight stays beyond the value limit until the number is flushed
  a_place_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (place_q > PLACE_LIMIT) |=> (place_q > PLACE_LIMIT || $past(accept && !hd_d)))
    else $error("digit weight dropped without a flush");

endmodule

`default_nettype wire

@@ rtl/pmee_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pmee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read returning old data on a collision
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire
